// File: rtl/tdi_pkg.sv
// ----------------------------------------------------------------------------
// tdi_pkg
// shared types, widths, constants and decode helpers of the thermometer
// display indicator
// ----------------------------------------------------------------------------
package tdi_pkg;

   localparam int ADC_FULL_SCALE_DEF = 4095;

   localparam int SAMPLE_W = 12;
   localparam int TEMP_W   = 12;
   localparam int PROD_W   = 24;
   localparam int MULT_W   = 26;
   localparam int QUOT_W   = 16;
   localparam int Q10_W    = 9;
   localparam int Q100_W   = 6;
   localparam int DIGIT_W  = 4;
   localparam int NUM_DIG  = 3;
   localparam int LEVEL_W  = 8;
   localparam int DUTY_W   = 16;
   localparam int SEG_W    = 7;
   localparam int CSR_IDX_W = 2;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 64;

   localparam logic [TEMP_W-1:0] TEMP_MAX = 12'd3300;

   localparam logic [TEMP_W-1:0] COLD_RESET = 12'd230;
   localparam logic [TEMP_W-1:0] MILD_RESET = 12'd250;
   localparam logic [TEMP_W-1:0] WARM_RESET = 12'd270;

   localparam logic [DUTY_W-1:0] DUTY_CLOSED = 16'd3276;
   localparam logic [DUTY_W-1:0] DUTY_MIDDLE = 16'd4095;
   localparam logic [DUTY_W-1:0] DUTY_OPEN   = 16'd6553;

   localparam logic [LEVEL_W-1:0] LEVEL_OFF = 8'd0;
   localparam logic [LEVEL_W-1:0] LEVEL_ON  = 8'd255;

   localparam logic [CSR_IDX_W-1:0] CSR_COLD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MILD = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WARM = 2'd2;

   localparam logic [1:0] POS_TENTHS = 2'd0;
   localparam logic [1:0] POS_UNITS  = 2'd1;
   localparam logic [1:0] POS_TENS   = 2'd2;

   typedef enum logic {
      CMD_SAMPLE = 1'b0,
      CMD_TICK   = 1'b1
   } cmd_type;

   typedef struct packed {
      cmd_type                                 cmd;
      logic [TEMP_W-1:0]                       temp;
      logic [NUM_DIG-1:0][DIGIT_W-1:0]         digits;
   } item_type;

   function automatic logic [SEG_W-1:0] seg_decode(input logic [DIGIT_W-1:0] d);
      logic [SEG_W-1:0] s;
      unique case (d)
         4'd0:    s = 7'h3F;
         4'd1:    s = 7'h06;
         4'd2:    s = 7'h5B;
         4'd3:    s = 7'h4F;
         4'd4:    s = 7'h66;
         4'd5:    s = 7'h6D;
         4'd6:    s = 7'h7D;
         4'd7:    s = 7'h07;
         4'd8:    s = 7'h7F;
         4'd9:    s = 7'h6F;
         default: s = 7'h00;
      endcase
      return s;
   endfunction

   function automatic logic [DIGIT_W-1:0] mod10_small(input logic [Q100_W-1:0] v);
      logic [Q100_W-1:0] r;
      priority if (v >= 6'd60) begin
         r = v - 6'd60;
      end else if (v >= 6'd50) begin
         r = v - 6'd50;
      end else if (v >= 6'd40) begin
         r = v - 6'd40;
      end else if (v >= 6'd30) begin
         r = v - 6'd30;
      end else if (v >= 6'd20) begin
         r = v - 6'd20;
      end else if (v >= 6'd10) begin
         r = v - 6'd10;
      end else begin
         r = v;
      end
      return r[DIGIT_W-1:0];
   endfunction

endpackage

// File: rtl/thermometer_display_indicator.sv
// ----------------------------------------------------------------------------
// thermometer_display_indicator
// converter reading to tenths of a degree, multiplexed seven-segment scan,
// rgb class indicator and servo duty
//
//   port group   dir   fields
//   req_*        in    tuser: command; tdata: adc_sample
//   rsp_*        out   tdata: display, indicator, servo and temperature
//   csr_*        in    write of cold, mild and warm limits
//
// one item per cycle sustained while results are taken; a result passes the input
// register, four arithmetic stages and the result register
// synchronous reset clears the display state and pipeline, reloads the limits
// a stalled result holds; upper stages keep moving until they fill
// ----------------------------------------------------------------------------
module thermometer_display_indicator #(
   parameter int ADC_FULL_SCALE = tdi_pkg::ADC_FULL_SCALE_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [tdi_pkg::REQ_DATA_W-1:0]   req_tdata,  // adc_sample
   input  logic                             req_tuser,  // command
   input  logic                             csr_wr_en,
   input  logic [tdi_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [tdi_pkg::TEMP_W-1:0]       csr_wdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // segments, digit_enable, decimal_point, red_level, green_level,
   // blue_level, servo_duty, temperature_tenths
   output logic [tdi_pkg::RSP_DATA_W-1:0]   rsp_tdata
);
   import tdi_pkg::*;

   logic     item_valid, item_ready;
   item_type item;

   tdi_convert #(
      .ADC_FULL_SCALE (ADC_FULL_SCALE)
   ) u_convert (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_cmd    (cmd_type'(req_tuser)),
      .in_sample (req_tdata[SAMPLE_W-1:0]),
      .out_valid (item_valid),
      .out_ready (item_ready),
      .out_item  (item)
   );

   tdi_display u_display (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item_ready (item_ready),
      .item       (item),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// File: rtl/tdi_convert.sv
// ----------------------------------------------------------------------------
// tdi_convert
// pipeline from converter reading to tenths of a degree and its three digits
// ----------------------------------------------------------------------------
module tdi_convert #(
   parameter int ADC_FULL_SCALE = tdi_pkg::ADC_FULL_SCALE_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  tdi_pkg::cmd_type               in_cmd,
   input  logic [tdi_pkg::SAMPLE_W-1:0]   in_sample,
   output logic                           out_valid,
   input  logic                           out_ready,
   output tdi_pkg::item_type              out_item
);
   import tdi_pkg::*;

   localparam int NumStages = 5;
   localparam int WideW     = PROD_W + MULT_W;
   localparam int DivShift  = PROD_W + $clog2(ADC_FULL_SCALE);
   localparam logic [63:0] DivMult =
      ((64'd1 << DivShift) + 64'(ADC_FULL_SCALE) - 64'd1) / 64'(ADC_FULL_SCALE);
   localparam logic [28:0] Recip10 = 29'd52429;
   localparam int Recip10Shift = 19;
   localparam logic [16:0] Recip10s = 17'd205;
   localparam int Recip10sShift = 11;

   logic [NumStages-1:0] vld_ff, vld_in, move;
   cmd_type              cmd_ff [NumStages];

   logic [SAMPLE_W-1:0]  sample_ff;
   logic [PROD_W-1:0]    prod_ff, prod_in;
   logic [QUOT_W-1:0]    quot_ff, quot_in;
   logic [WideW-1:0]     wide_prod;
   logic [TEMP_W-1:0]    temp3_ff, temp3_in, temp4_ff;
   logic [28:0]          t10_prod;
   logic [Q10_W-1:0]     q10_3_ff, q10_3_in, q10_4_ff;
   logic [16:0]          t100_prod;
   logic [Q100_W-1:0]    q100_ff, q100_in;
   logic [TEMP_W-1:0]    ones_full;
   logic [DIGIT_W-1:0]   ones_ff, ones_in;
   logic [Q10_W-1:0]     units_full;

   always_comb begin
      move[NumStages-1] = vld_ff[NumStages-1] && out_ready;
      for (int k = NumStages - 2; k >= 0; k--) begin
         move[k] = vld_ff[k] && (!vld_ff[k+1] || move[k+1]);
      end
      in_ready = !vld_ff[0] || move[0];
      vld_in[0] = (in_valid && in_ready) ? 1'b1 : (move[0] ? 1'b0 : vld_ff[0]);
      for (int k = 1; k < NumStages; k++) begin
         vld_in[k] = move[k-1] ? 1'b1 : (move[k] ? 1'b0 : vld_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // scaling by 3300 / full scale through an exact reciprocal
   always_comb begin
      prod_in   = PROD_W'(sample_ff) * PROD_W'(TEMP_MAX);
      wide_prod = WideW'(prod_ff) * WideW'(DivMult[MULT_W-1:0]);
      quot_in   = QUOT_W'(wide_prod >> DivShift);
      temp3_in  = (quot_ff > QUOT_W'(TEMP_MAX)) ? TEMP_MAX : quot_ff[TEMP_W-1:0];
      t10_prod  = 29'(temp3_in) * Recip10;
      q10_3_in  = Q10_W'(t10_prod >> Recip10Shift);
      t100_prod = 17'(q10_3_ff) * Recip10s;
      q100_in   = Q100_W'(t100_prod >> Recip10sShift);
      ones_full = temp3_ff - TEMP_W'(q10_3_ff) * TEMP_W'(10);
      ones_in   = ones_full[DIGIT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         cmd_ff[0] <= in_cmd;
         sample_ff <= in_sample;
      end
      if (move[0]) begin
         cmd_ff[1] <= cmd_ff[0];
         prod_ff   <= prod_in;
      end
      if (move[1]) begin
         cmd_ff[2] <= cmd_ff[1];
         quot_ff   <= quot_in;
      end
      if (move[2]) begin
         cmd_ff[3] <= cmd_ff[2];
         temp3_ff  <= temp3_in;
         q10_3_ff  <= q10_3_in;
      end
      if (move[3]) begin
         cmd_ff[4] <= cmd_ff[3];
         temp4_ff  <= temp3_ff;
         q10_4_ff  <= q10_3_ff;
         q100_ff   <= q100_in;
         ones_ff   <= ones_in;
      end
   end

   always_comb begin
      units_full         = q10_4_ff - Q10_W'(q100_ff) * Q10_W'(10);
      out_valid          = vld_ff[NumStages-1];
      out_item.cmd       = cmd_ff[NumStages-1];
      out_item.temp      = temp4_ff;
      out_item.digits[0] = ones_ff;
      out_item.digits[1] = units_full[DIGIT_W-1:0];
      out_item.digits[2] = mod10_small(q100_ff);
   end

endmodule

// File: rtl/tdi_display.sv
// ----------------------------------------------------------------------------
// tdi_display
// display state, scan multiplexer, indicator classes and result register
// ----------------------------------------------------------------------------
module tdi_display (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             item_valid,
   output logic                             item_ready,
   input  tdi_pkg::item_type                item,
   input  logic                             csr_wr_en,
   input  logic [tdi_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [tdi_pkg::TEMP_W-1:0]       csr_wdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [tdi_pkg::RSP_DATA_W-1:0]   rsp_tdata
);
   import tdi_pkg::*;

   logic [TEMP_W-1:0] cold_ff, mild_ff, warm_ff;

   logic [TEMP_W-1:0]               temp_ff, temp_in;
   logic [NUM_DIG-1:0][DIGIT_W-1:0] dig_ff, dig_in;
   logic [1:0]                      scan_ff, scan_in, pos_ff, pos_in, pos_now;
   logic                            shown_ff, shown_in;

   logic                 rsp_valid_ff, rsp_valid_in, take;
   logic [SEG_W-1:0]     seg_ff, seg_in;
   logic [NUM_DIG-1:0]   en_ff, en_in;
   logic                 dp_ff, dp_in;
   logic [LEVEL_W-1:0]   red_ff, red_in, green_ff, green_in, blue_ff, blue_in;
   logic [DUTY_W-1:0]    duty_ff, duty_in;

   assign item_ready = !rsp_valid_ff || rsp_tready;
   assign take       = item_valid && item_ready;
   assign rsp_valid_in = take ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         cold_ff <= COLD_RESET;
         mild_ff <= MILD_RESET;
         warm_ff <= WARM_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_COLD: cold_ff <= csr_wdata;
            CSR_MILD: mild_ff <= csr_wdata;
            CSR_WARM: warm_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      temp_in  = temp_ff;
      dig_in   = dig_ff;
      scan_in  = scan_ff;
      pos_in   = pos_ff;
      shown_in = shown_ff;
      pos_now  = (scan_ff == 2'd3) ? POS_TENTHS : scan_ff;
      unique case (item.cmd)
         CMD_SAMPLE: begin
            temp_in = item.temp;
            dig_in  = item.digits;
         end
         CMD_TICK: begin
            pos_in   = pos_now;
            shown_in = 1'b1;
            scan_in  = (pos_now == POS_TENS) ? POS_TENTHS : pos_now + 2'd1;
         end
         default: ;
      endcase

      if (shown_in) begin
         seg_in = seg_decode(dig_in[pos_in]);
         en_in  = NUM_DIG'(1) << pos_in;
         dp_in  = (pos_in == POS_UNITS);
      end else begin
         seg_in = '0;
         en_in  = '0;
         dp_in  = 1'b0;
      end

      priority if (temp_in < cold_ff) begin
         red_in = LEVEL_OFF; green_in = LEVEL_OFF; blue_in = LEVEL_ON;
         duty_in = DUTY_CLOSED;
      end else if (temp_in < mild_ff) begin
         red_in = LEVEL_OFF; green_in = LEVEL_ON; blue_in = LEVEL_OFF;
         duty_in = DUTY_MIDDLE;
      end else if (temp_in < warm_ff) begin
         red_in = LEVEL_ON; green_in = LEVEL_ON; blue_in = LEVEL_OFF;
         duty_in = DUTY_MIDDLE;
      end else begin
         red_in = LEVEL_ON; green_in = LEVEL_OFF; blue_in = LEVEL_OFF;
         duty_in = DUTY_OPEN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_ff      <= '0;
         dig_ff       <= '0;
         scan_ff      <= POS_TENTHS;
         pos_ff       <= POS_TENTHS;
         shown_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (take) begin
            temp_ff  <= temp_in;
            dig_ff   <= dig_in;
            scan_ff  <= scan_in;
            pos_ff   <= pos_in;
            shown_ff <= shown_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         seg_ff   <= seg_in;
         en_ff    <= en_in;
         dp_ff    <= dp_in;
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
         duty_ff  <= duty_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, temp_ff, duty_ff, blue_ff, green_ff, red_ff,
                        dp_ff, en_ff, seg_ff};

`ifndef ASSERT_OFF
   a_scan_range: assert property (@(posedge clock) disable iff (reset)
      scan_ff != 2'd3)
      else $error("scan index left its range");

   a_enable_onehot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $onehot0(en_ff))
      else $error("more than one digit enabled");

   a_point_on_units: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && dp_ff) |-> (en_ff == 3'b010))
      else $error("decimal point away from units digit");

   a_temp_range: assert property (@(posedge clock) disable iff (reset)
      temp_ff <= TEMP_MAX)
      else $error("temperature above full range");

   a_blue_alone: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && blue_ff == LEVEL_ON) |->
         (red_ff == LEVEL_OFF && duty_ff == DUTY_CLOSED))
      else $error("cold class mixed with another");
`endif

endmodule

// File: sim/thermometer_display_indicator_checker.sv
// ----------------------------------------------------------------------------
// thermometer_display_indicator_checker
// watches the request, result and limit-write ports of the thermometer
// display indicator, predicts every result from its own copy of the display
// scan, temperature and limits, and compares the results in order, field by
// field
// ----------------------------------------------------------------------------
module thermometer_display_indicator_checker #(
   parameter int FULL_SCALE = tdi_pkg::ADC_FULL_SCALE_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [tdi_pkg::REQ_DATA_W-1:0]   req_tdata,  // adc_sample
   input  logic                             req_tuser,  // command
   input  logic                             csr_wr_en,
   input  logic [tdi_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [tdi_pkg::TEMP_W-1:0]       csr_wdata,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // segments, digit_enable, decimal_point, red_level, green_level,
   // blue_level, servo_duty, temperature_tenths
   input  logic [tdi_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output int                               mismatch_count,
   output int                               pending_results
);

   import tdi_pkg::*;

   typedef struct packed {
      logic                 pad;
      logic [TEMP_W-1:0]    temp;
      logic [DUTY_W-1:0]    duty;
      logic [LEVEL_W-1:0]   blue;
      logic [LEVEL_W-1:0]   green;
      logic [LEVEL_W-1:0]   red;
      logic                 dp;
      logic [NUM_DIG-1:0]   enable;
      logic [SEG_W-1:0]     segs;
   } display_word_type;

   display_word_type expected_displays [$];

   logic [TEMP_W-1:0]               cold_lim;
   logic [TEMP_W-1:0]               mild_lim;
   logic [TEMP_W-1:0]               warm_lim;
   logic [TEMP_W-1:0]               temp_now;
   logic [NUM_DIG-1:0][DIGIT_W-1:0] digit_now;
   logic [1:0]                      scan_pos;
   logic [1:0]                      shown_pos;
   logic                            scan_seen;

   function automatic display_word_type predict_display(input cmd_type cmd,
                                                        input logic [SAMPLE_W-1:0] sample);
      display_word_type w;
      int unsigned      t;
      logic [1:0]       pos;
      logic [DIGIT_W-1:0] d;
      w = '0;
      if (cmd == CMD_SAMPLE) begin
         t = (int'(sample) * int'(TEMP_MAX)) / FULL_SCALE;
         if (t > int'(TEMP_MAX)) begin
            t = TEMP_MAX;
         end
         temp_now     = TEMP_W'(t);
         digit_now[0] = DIGIT_W'(t % 10);
         digit_now[1] = DIGIT_W'((t / 10) % 10);
         // hundreds wrap away
         digit_now[2] = DIGIT_W'((t / 100) % 10);
      end else begin
         pos = (scan_pos > POS_TENS) ? POS_TENTHS : scan_pos;
         shown_pos = pos;
         scan_seen = 1'b1;
         scan_pos  = (pos >= POS_TENS) ? POS_TENTHS : pos + 2'd1;
      end

      if (scan_seen) begin
         d = digit_now[shown_pos];
         case (d)
            4'd0:    w.segs = 7'h3F;
            4'd1:    w.segs = 7'h06;
            4'd2:    w.segs = 7'h5B;
            4'd3:    w.segs = 7'h4F;
            4'd4:    w.segs = 7'h66;
            4'd5:    w.segs = 7'h6D;
            4'd6:    w.segs = 7'h7D;
            4'd7:    w.segs = 7'h07;
            4'd8:    w.segs = 7'h7F;
            4'd9:    w.segs = 7'h6F;
            default: w.segs = 7'h00;
         endcase
         w.enable = 3'b001 << shown_pos;
         w.dp     = (shown_pos == POS_UNITS);
      end

      // ordered tests, each only if the previous one failed
      if (temp_now < cold_lim) begin
         w.blue = LEVEL_ON;
         w.duty = DUTY_CLOSED;
      end else if (temp_now < mild_lim) begin
         w.green = LEVEL_ON;
         w.duty  = DUTY_MIDDLE;
      end else if (temp_now < warm_lim) begin
         w.red   = LEVEL_ON;
         w.green = LEVEL_ON;
         w.duty  = DUTY_MIDDLE;
      end else begin
         w.red  = LEVEL_ON;
         w.duty = DUTY_OPEN;
      end
      w.temp = temp_now;
      return w;
   endfunction

   task automatic compare_field(input string field, input int unsigned want_v,
                                input int unsigned got_v);
      if (want_v != got_v) begin
         $error("%s: expected %0d, got %0d", field, want_v, got_v);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin : monitor
      display_word_type got;
      display_word_type want;
      if (reset) begin
         cold_lim       = COLD_RESET;
         mild_lim       = MILD_RESET;
         warm_lim       = WARM_RESET;
         temp_now       = '0;
         digit_now      = '0;
         scan_pos       = POS_TENTHS;
         shown_pos      = POS_TENTHS;
         scan_seen      = 1'b0;
         mismatch_count = 0;
         expected_displays.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_COLD: cold_lim = csr_wdata;
               CSR_MILD: mild_lim = csr_wdata;
               CSR_WARM: warm_lim = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (expected_displays.size() == 0) begin
               $error("result item with no expected result, data %h", rsp_tdata);
               mismatch_count++;
            end else begin
               want = expected_displays.pop_front();
               compare_field("segments", want.segs, got.segs);
               compare_field("digit_enable", want.enable, got.enable);
               compare_field("decimal_point", want.dp, got.dp);
               compare_field("red_level", want.red, got.red);
               compare_field("green_level", want.green, got.green);
               compare_field("blue_level", want.blue, got.blue);
               compare_field("servo_duty", want.duty, got.duty);
               compare_field("temperature_tenths", want.temp, got.temp);
            end
         end
         if (req_tvalid && req_tready) begin
            expected_displays.push_back(predict_display(cmd_type'(req_tuser),
                                                        req_tdata[SAMPLE_W-1:0]));
         end
      end
      pending_results <= expected_displays.size();
   end

endmodule

// File: sim/thermometer_display_indicator_tb.sv
// ----------------------------------------------------------------------------
// thermometer_display_indicator_tb
// drives sample and scan-tick items with random gaps and result back-pressure,
// including one long receiver hold-off, and steps the cold, mild and warm
// limits through zero, full scale, unordered and random settings between
// phases; the checker predicts and compares every result
// ----------------------------------------------------------------------------
module thermometer_display_indicator_tb;

   import tdi_pkg::*;

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    req_tvalid;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata;  // adc_sample
   logic                    req_tuser;  // command
   logic                    csr_wr_en;
   logic [CSR_IDX_W-1:0]    csr_index;
   logic [TEMP_W-1:0]       csr_wdata;
   logic                    rsp_tvalid;
   logic                    rsp_tready;
   // segments, digit_enable, decimal_point, red_level, green_level,
   // blue_level, servo_duty, temperature_tenths
   logic [RSP_DATA_W-1:0]   rsp_tdata;

   int mismatch_count;
   int pending_results;
   int limits_now [3];
   int burst_left;
   bit hold_request;
   bit hold_active;
   bit hold_done;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   thermometer_display_indicator u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   thermometer_display_indicator_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .mismatch_count  (mismatch_count),
      .pending_results (pending_results)
   );

   task automatic send_item(input cmd_type cmd, input logic [SAMPLE_W-1:0] sample);
      int gap;
      int r;
      r = $urandom_range(0, 99);
      if (hold_active || burst_left > 0) begin
         gap = 0;
         if (burst_left > 0) begin
            burst_left--;
         end
      end else if (r < 3) begin
         burst_left = 40;
         gap = 0;
      end else if (r < 60) begin
         gap = 0;
      end else if (r < 92) begin
         gap = $urandom_range(1, 3);
      end else begin
         gap = $urandom_range(8, 30);
      end
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {4'b0000, sample};
      do @(posedge clock); while (!req_tready);
   endtask

   // wait until every result is in
   task automatic settle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_results != 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_limit(input logic [CSR_IDX_W-1:0] idx, input int value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= TEMP_W'(value);
      limits_now[idx] = value;
      @(posedge clock);
   endtask

   task automatic set_limits(input int cold, input int mild, input int warm);
      settle();
      write_limit(CSR_COLD, cold);
      write_limit(CSR_MILD, mild);
      write_limit(CSR_WARM, warm);
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [SAMPLE_W-1:0] pick_sample();
      int v;
      int base;
      case ($urandom_range(0, 3))
         0, 1: v = $urandom_range(0, 4095);
         2: begin
            // near one of the limits
            base = limits_now[$urandom_range(0, 2)] * ADC_FULL_SCALE_DEF / int'(TEMP_MAX);
            v = base + int'($urandom_range(0, 6)) - 3;
         end
         default: v = $urandom_range(4000, 4095);
      endcase
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
      return SAMPLE_W'(v);
   endfunction

   initial begin : receiver
      rsp_tready = 1'b0;
      hold_active = 1'b0;
      hold_done = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_request && !hold_done) begin
            hold_active = 1'b1;
            rsp_tready <= 1'b0;
            repeat (120) @(posedge clock);
            hold_active = 1'b0;
            hold_done = 1'b1;
         end else begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4: begin
                  rsp_tready <= 1'b1;
                  repeat ($urandom_range(1, 20)) @(posedge clock);
               end
               5, 6, 7: begin
                  rsp_tready <= 1'b0;
                  repeat ($urandom_range(1, 3)) @(posedge clock);
               end
               8: begin
                  rsp_tready <= 1'b0;
                  repeat ($urandom_range(10, 40)) @(posedge clock);
               end
               default: begin
                  rsp_tready <= 1'b1;
                  repeat ($urandom_range(30, 60)) @(posedge clock);
               end
            endcase
         end
      end
   end

   initial begin : stimulus
      int a;
      int b;
      int c;
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = CMD_SAMPLE;
      csr_wr_en    = 1'b0;
      csr_index    = CSR_COLD;
      csr_wdata    = '0;
      burst_left   = 0;
      hold_request = 1'b0;
      limits_now[CSR_COLD] = COLD_RESET;
      limits_now[CSR_MILD] = MILD_RESET;
      limits_now[CSR_WARM] = WARM_RESET;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // blank display until the first tick, full scale, scan wrap
      send_item(CMD_SAMPLE, 12'd0);
      send_item(CMD_SAMPLE, 12'd4095);
      send_item(CMD_TICK, 12'd0);
      send_item(CMD_TICK, 12'hFFF);
      send_item(CMD_TICK, 12'd0);
      send_item(CMD_TICK, 12'd0);
      send_item(CMD_TICK, 12'd0);
      send_item(CMD_SAMPLE, 12'h555);
      send_item(CMD_SAMPLE, 12'hAAA);
      // either side of each default limit
      send_item(CMD_SAMPLE, 12'd285);
      send_item(CMD_SAMPLE, 12'd286);
      send_item(CMD_SAMPLE, 12'd310);
      send_item(CMD_SAMPLE, 12'd311);
      send_item(CMD_SAMPLE, 12'd335);
      send_item(CMD_SAMPLE, 12'd336);
      send_item(CMD_TICK, 12'h5A5);
      send_item(CMD_TICK, 12'd0);
      send_item(CMD_SAMPLE, 12'd1);
      send_item(CMD_SAMPLE, 12'd4094);
      send_item(CMD_SAMPLE, 12'd2048);
      send_item(CMD_TICK, 12'd0);

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: set_limits(0, 0, 0);
            1: set_limits(TEMP_MAX, TEMP_MAX, TEMP_MAX);
            // unordered limits
            2: set_limits(3000, 1000, 2000);
            3: begin
               a = $urandom_range(0, 1100);
               b = a + $urandom_range(0, 1100);
               c = b + $urandom_range(0, 1100);
               set_limits(a, b, c);
            end
            4: set_limits($urandom_range(0, 3300), $urandom_range(0, 3300),
                          $urandom_range(0, 3300));
            default: set_limits(COLD_RESET, MILD_RESET, WARM_RESET);
         endcase
         if (phase == 1) begin
            hold_request = 1'b1;
         end
         for (int i = 0; i < 115; i++) begin
            if ($urandom_range(0, 1) == 0) begin
               send_item(CMD_TICK, SAMPLE_W'($urandom_range(0, 4095)));
            end else begin
               send_item(CMD_SAMPLE, pick_sample());
            end
         end
      end

      settle();
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin : watchdog
      #2000000;
      $display("Mismatches found");
      $finish;
   end

endmodule
